// ===== rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and constants of the byte ring fifo with big-endian word reads.
// ----------------------------------------------------------------------------
package brf_pkg;

  // default sizes
  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned MAX_BURST_DEF = 64;

  // fixed field widths
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned FILL_W = 10;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned ACC_W  = 24;

  // widest write or word request in bytes
  localparam int unsigned WORD_BYTES = 4;

  // request codes
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_READ   = 3'd1,
    CMD_PEEK   = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_WORD   = 3'd4,
    CMD_QUERY  = 3'd5
  } cmd_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_SHORT    = 2'd2,
    ST_BAD      = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WRITE,
    S_READ
  } state_e;

endpackage

// ===== rtl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module brf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/byte_ring_fifo_be_reads.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_be_reads
// Byte ring of DEPTH slots holding up to DEPTH-1 bytes, with burst reads,
// peeks, removes, big-endian word reads and a fill query.
// ----------------------------------------------------------------------------
//  channel   | signals                                       | direction
//  ----------+-----------------------------------------------+----------
//  request   | start, cmd_i, value_i, count_i; busy is out   | in
//  result    | strobe_o, result_value_o, last_o, fill_o,     | out
//            | status_o                                      |
//
//  Remove, query and every rejected request keep busy low: the registered
//  result appears in the cycle after the request. A write of n bytes holds
//  busy, writing one byte per cycle through the single RAM write port; its
//  result appears right after the request. A read or peek of n bytes holds
//  busy, returning one byte per cycle via the RAM read and result registers;
//  a word read also holds busy, limited by the single RAM read port, and
//  its result appears in the same cycle that busy drops. Reset clears the
//  head and tail pointers and control state only; stored bytes are undefined
//  until written. The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module byte_ring_fifo_be_reads
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [CNT_W-1:0]  count_i,
  output logic              strobe_o,
  output logic [VAL_W-1:0]  result_value_o,
  output logic              last_o,
  output logic [FILL_W-1:0] fill_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  // modular pointer advance, k stays below DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] p,
                                             input logic [AW-1:0] k);
    logic [AW:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_e            state_q, state_d;
  logic [AW-1:0]     head_q, head_d;
  logic [AW-1:0]     tail_q, tail_d;
  logic [AW-1:0]     rp_q, rp_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              word_q, word_d;
  status_e           bst_q, bst_d;
  logic [FILL_W-1:0] fill_res_q, fill_res_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [VAL_W-1:0]  wr_sh_q, wr_sh_d;

  logic              strobe_q, strobe_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic              last_q, last_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  status_e           status_q, status_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [BYTE_W-1:0] ram_wdata, ram_rdata;

  logic [AW:0]       lvl_diff;
  logic [AW-1:0]     lvl;
  logic [SW-1:0]     f_s, c_s, n_s;
  logic [AW-1:0]     n_a, c_a;
  logic              bad_word, bad_burst, ovf;

  // byte store
  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // fill level and request checks
  always_comb begin
    lvl_diff  = {1'b0, tail_q} - {1'b0, head_q};
    if (tail_q < head_q) begin
      lvl_diff = lvl_diff + (AW+1)'(DEPTH);
    end
    lvl       = lvl_diff[AW-1:0];
    f_s       = SW'(lvl);
    c_s       = SW'(count_i);
    n_s       = (f_s < c_s) ? f_s : c_s;
    n_a       = AW'(n_s);
    c_a       = AW'(c_s);
    bad_word  = (c_s == '0) || (c_s > SW'(WORD_BYTES));
    bad_burst = (c_s == '0) || (c_s > SW'(MAX_BURST));
    ovf       = (f_s + c_s) > SW'(DEPTH - 1);
  end

  // sequencer: next state, RAM access and results
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    rem_d       = rem_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    word_d      = word_q;
    bst_d       = bst_q;
    fill_res_d  = fill_res_q;
    acc_d       = acc_q;
    wr_sh_d     = wr_sh_q;
    strobe_d    = 1'b0;
    value_d     = value_q;
    last_d      = last_q;
    fill_d      = fill_q;
    status_d    = status_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = wp_q;
    ram_raddr   = rp_q;
    ram_wdata   = wr_sh_q[VAL_W-1 -: BYTE_W];

    case (state_q)
      S_IDLE: begin
        if (start) begin
          acc_d    = '0;
          strobe_d = 1'b1;
          last_d   = 1'b1;
          value_d  = '0;
          fill_d   = FILL_W'(lvl);
          status_d = ST_OK;
          case (cmd_e'(cmd_i))
            CMD_WRITE: begin
              if (bad_word) begin
                status_d = ST_BAD;
              end else if (ovf) begin
                status_d = ST_OVERFLOW;
              end else begin
                tail_d  = wrap_add(tail_q, c_a);
                fill_d  = FILL_W'(f_s + c_s);
                wp_d    = tail_q;
                rem_d   = count_i;
                state_d = S_WRITE;
                // first byte to the top of the shifter
                case (count_i[1:0])
                  2'd1:    wr_sh_d = value_i << (3 * BYTE_W);
                  2'd2:    wr_sh_d = value_i << (2 * BYTE_W);
                  2'd3:    wr_sh_d = value_i << BYTE_W;
                  default: wr_sh_d = value_i;
                endcase
              end
            end
            CMD_READ, CMD_PEEK: begin
              if (bad_burst) begin
                status_d = ST_BAD;
              end else if (lvl == '0) begin
                status_d = ST_SHORT;
              end else begin
                strobe_d = 1'b0;
                rp_d     = head_q;
                rem_d    = CNT_W'(n_s);
                word_d   = 1'b0;
                bst_d    = (n_s < c_s) ? ST_SHORT : ST_OK;
                state_d  = S_READ;
                if (cmd_e'(cmd_i) == CMD_READ) begin
                  head_d     = wrap_add(head_q, n_a);
                  fill_res_d = FILL_W'(f_s - n_s);
                end else begin
                  fill_res_d = FILL_W'(lvl);
                end
              end
            end
            CMD_REMOVE: begin
              if (bad_burst) begin
                status_d = ST_BAD;
              end else begin
                head_d   = wrap_add(head_q, n_a);
                value_d  = VAL_W'(n_s);
                fill_d   = FILL_W'(f_s - n_s);
                status_d = (n_s < c_s) ? ST_SHORT : ST_OK;
              end
            end
            CMD_WORD: begin
              if (bad_word) begin
                status_d = ST_BAD;
              end else if (f_s < c_s) begin
                status_d = ST_SHORT;
              end else begin
                strobe_d   = 1'b0;
                rp_d       = head_q;
                rem_d      = count_i;
                word_d     = 1'b1;
                bst_d      = ST_OK;
                head_d     = wrap_add(head_q, c_a);
                fill_res_d = FILL_W'(f_s - c_s);
                state_d    = S_READ;
              end
            end
            CMD_QUERY: begin
              value_d = VAL_W'(DEPTH - 1);
            end
            default: begin
              status_d = ST_BAD;
            end
          endcase
        end
      end

      S_WRITE: begin
        // one byte per cycle into the ring
        ram_we  = 1'b1;
        wp_d    = wrap_add(wp_q, AW'(1));
        wr_sh_d = wr_sh_q << BYTE_W;
        rem_d   = rem_q - CNT_W'(1);
        if (rem_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end

      S_READ: begin
        // issue reads while bytes remain
        if (rem_q != '0) begin
          ram_re      = 1'b1;
          rp_d        = wrap_add(rp_q, AW'(1));
          rem_d       = rem_q - CNT_W'(1);
          pend_d      = 1'b1;
          pend_last_d = (rem_q == CNT_W'(1));
        end
        // consume returning read data
        if (pend_q) begin
          if (word_q) begin
            acc_d = {acc_q[ACC_W-BYTE_W-1:0], ram_rdata};
            if (pend_last_q) begin
              strobe_d = 1'b1;
              value_d  = {acc_q, ram_rdata};
              last_d   = 1'b1;
              fill_d   = fill_res_q;
              status_d = bst_q;
            end
          end else begin
            strobe_d = 1'b1;
            value_d  = VAL_W'(ram_rdata);
            last_d   = pend_last_q;
            fill_d   = fill_res_q;
            status_d = bst_q;
          end
          if (pend_last_q) begin
            state_d = S_IDLE;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      rem_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
      strobe_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
      strobe_q    <= strobe_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rp_q       <= rp_d;
    wp_q       <= wp_d;
    word_q     <= word_d;
    bst_q      <= bst_d;
    fill_res_q <= fill_res_d;
    acc_q      <= acc_d;
    wr_sh_q    <= wr_sh_d;
    value_q    <= value_d;
    last_q     <= last_d;
    fill_q     <= fill_d;
    status_q   <= status_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign strobe_o       = strobe_q;
  assign result_value_o = value_q;
  assign last_o         = last_q;
  assign fill_o         = fill_q;
  assign status_o       = status_q;

  // read data only returns while a read request is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_READ))
    else $error("read data pending outside read state");

  // the final read issue is followed by the final data beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && rem_q == CNT_W'(1)) |=> (pend_q && pend_last_q))
    else $error("last read issue lost");

  // the final data beat ends the request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && pend_q && pend_last_q) |=> (state_q == S_IDLE && strobe_o))
    else $error("read request did not finish with a result");

  // a write always leaves one free slot ahead of the oldest stored byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> (wrap_add(wp_q, AW'(1)) != head_q))
    else $error("write overran the read pointer");

endmodule

// ===== tb/sv/byte_ring_fifo_be_reads_checker.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_be_reads_checker
// Watches the request and result channels of the byte ring fifo, keeps its
// own copy of the ring and pointers, works out the results of each accepted
// request and compares every strobed result, field by field, in order.
// ----------------------------------------------------------------------------
module byte_ring_fifo_be_reads_checker
  import brf_pkg::*;
#(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned MAX_BURST = MAX_BURST_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [CMD_W-1:0]  cmd_i,
  input  logic [VAL_W-1:0]  value_i,
  input  logic [CNT_W-1:0]  count_i,
  input  logic              strobe_i,
  input  logic [VAL_W-1:0]  result_value_i,
  input  logic              last_i,
  input  logic [FILL_W-1:0] fill_i,
  input  logic [STAT_W-1:0] status_i,
  output int unsigned       fail_count_o,
  output int unsigned       pending_o,
  output int unsigned       overflow_count_o
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic              last;
    logic [FILL_W-1:0] fill;
    status_e           status;
  } ring_result_t;

  // shadow ring and pointers
  logic [BYTE_W-1:0] ring_bytes [DEPTH];
  int unsigned       oldest_slot;
  int unsigned       free_slot;

  // results still owed by the block, oldest first
  ring_result_t      owed_results [$];
  ring_result_t      oldest_owed;

  function automatic int unsigned stored_bytes();
    return (free_slot + DEPTH - oldest_slot) % DEPTH;
  endfunction

  // fill is taken from the shadow state at the time of the call
  function automatic void owe_result(logic [VAL_W-1:0] value, logic last, status_e status);
    ring_result_t res;
    res.value  = value;
    res.last   = last;
    res.fill   = FILL_W'(stored_bytes());
    res.status = status;
    owed_results.push_back(res);
  endfunction

  // apply one request to the shadow ring and queue what it returns
  function automatic void predict_ring_request(logic [CMD_W-1:0] cmd,
                                               logic [VAL_W-1:0] value,
                                               logic [CNT_W-1:0] count);
    int unsigned      level;
    int unsigned      take;
    int unsigned      pos;
    int unsigned      idx;
    logic [VAL_W-1:0] word;
    status_e          burst_status;
    level = stored_bytes();
    case (cmd)
      CMD_WRITE: begin
        if (count < 1 || count > WORD_BYTES) begin
          owe_result('0, 1'b1, ST_BAD);
        end else if (DEPTH - 1 - level < count) begin
          owe_result('0, 1'b1, ST_OVERFLOW);
          overflow_count_o++;
        end else begin
          // first byte is the most significant of the used ones
          for (idx = count; idx > 0; idx--) begin
            ring_bytes[free_slot] = value[8*(idx-1) +: 8];
            free_slot = (free_slot + 1) % DEPTH;
          end
          owe_result('0, 1'b1, ST_OK);
        end
      end
      CMD_READ, CMD_PEEK: begin
        if (count < 1 || count > MAX_BURST) begin
          owe_result('0, 1'b1, ST_BAD);
        end else if (level == 0) begin
          owe_result('0, 1'b1, ST_SHORT);
        end else begin
          take = (level < count) ? level : count;
          burst_status = (take < count) ? ST_SHORT : ST_OK;
          pos = oldest_slot;
          // every byte reports the level after the whole request
          if (cmd == CMD_READ) oldest_slot = (oldest_slot + take) % DEPTH;
          for (idx = 0; idx < take; idx++) begin
            owe_result(VAL_W'(ring_bytes[pos]), idx + 1 == take, burst_status);
            pos = (pos + 1) % DEPTH;
          end
        end
      end
      CMD_REMOVE: begin
        if (count < 1 || count > MAX_BURST) begin
          owe_result('0, 1'b1, ST_BAD);
        end else begin
          take = (level < count) ? level : count;
          oldest_slot = (oldest_slot + take) % DEPTH;
          owe_result(VAL_W'(take), 1'b1, (take < count) ? ST_SHORT : ST_OK);
        end
      end
      CMD_WORD: begin
        if (count < 1 || count > WORD_BYTES) begin
          owe_result('0, 1'b1, ST_BAD);
        end else if (level < count) begin
          // short word consumes nothing
          owe_result('0, 1'b1, ST_SHORT);
        end else begin
          word = '0;
          for (idx = 0; idx < count; idx++) begin
            word = {word[VAL_W-BYTE_W-1:0], ring_bytes[oldest_slot]};
            oldest_slot = (oldest_slot + 1) % DEPTH;
          end
          owe_result(word, 1'b1, ST_OK);
        end
      end
      CMD_QUERY: owe_result(VAL_W'(DEPTH - 1), 1'b1, ST_OK);
      default:   owe_result('0, 1'b1, ST_BAD);
    endcase
  endfunction

  // results are checked before the request of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_results.delete();
      oldest_slot      = 0;
      free_slot        = 0;
      fail_count_o     = 0;
      pending_o        = 0;
      overflow_count_o = 0;
    end else begin
      if (strobe_i !== 1'b0) begin
        if (owed_results.size() == 0) begin
          if (fail_count_o < MAX_REPORTS)
            $display("unexpected result: value %h last %b fill %0d status %0d",
                     result_value_i, last_i, fill_i, status_i);
          fail_count_o++;
        end else begin
          oldest_owed = owed_results.pop_front();
          if (result_value_i !== oldest_owed.value || last_i !== oldest_owed.last ||
              fill_i !== oldest_owed.fill || status_i !== oldest_owed.status) begin
            if (fail_count_o < MAX_REPORTS) begin
              $display("result mismatch: expected value %h last %b fill %0d status %0d",
                       oldest_owed.value, oldest_owed.last, oldest_owed.fill,
                       oldest_owed.status);
              $display("                 got      value %h last %b fill %0d status %0d",
                       result_value_i, last_i, fill_i, status_i);
            end
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) predict_ring_request(cmd_i, value_i, count_i);
      pending_o = owed_results.size();
    end
  end

endmodule

// ===== tb/sv/byte_ring_fifo_be_reads_tb.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo_be_reads_tb
// Drives requests into the byte ring fifo: a directed pass over bad counts,
// empty and short cases and every request code, then random traffic that
// mixes, fills the ring into overflow, drains it and wraps the pointers.
// The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module byte_ring_fifo_be_reads_tb;
  import brf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT     = 400000;
  localparam int unsigned ITEM_TARGET   = 470;
  localparam int unsigned OVERFLOW_GOAL = 6;
  localparam int unsigned SETTLE_CYCLES = 80;

  // codes the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;

  typedef enum logic [1:0] {
    MIX_BALANCED,
    MIX_FILL,
    MIX_DRAIN
  } traffic_mix_e;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd_i;
  logic [VAL_W-1:0]  value_i;
  logic [CNT_W-1:0]  count_i;
  logic              strobe_o;
  logic [VAL_W-1:0]  result_value_o;
  logic              last_o;
  logic [FILL_W-1:0] fill_o;
  logic [STAT_W-1:0] status_o;

  int unsigned       fail_count;
  int unsigned       pending_results;
  int unsigned       overflow_count;
  int unsigned       request_count;
  int unsigned       cycle_count;
  int unsigned       fill_requests;
  bit                no_idle;

  byte_ring_fifo_be_reads DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .count_i        (count_i),
    .strobe_o       (strobe_o),
    .result_value_o (result_value_o),
    .last_o         (last_o),
    .fill_o         (fill_o),
    .status_o       (status_o)
  );

  byte_ring_fifo_be_reads_checker ring_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .cmd_i            (cmd_i),
    .value_i          (value_i),
    .count_i          (count_i),
    .strobe_i         (strobe_o),
    .result_value_i   (result_value_o),
    .last_i           (last_o),
    .fill_i           (fill_o),
    .status_i         (status_o),
    .fail_count_o     (fail_count),
    .pending_o        (pending_results),
    .overflow_count_o (overflow_count)
  );

  always #5ns clk_i = ~clk_i;

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // hold the request until an edge with busy low takes it
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] value,
                              input logic [CNT_W-1:0] count);
    start   <= 1'b1;
    cmd_i   <= cmd;
    value_i <= value;
    count_i <= count;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    request_count++;
  endtask

  // idle gap with noise on the request fields
  task automatic pace_requests();
    int unsigned gap;
    int unsigned roll;
    if (request_count % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) gap = 0;
    else if (roll < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap != 0) begin
      start   <= 1'b0;
      cmd_i   <= CMD_W'($urandom);
      value_i <= $urandom;
      count_i <= CNT_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // stop sending until every owed result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
  endtask

  // mostly legal counts, sometimes zero or above the limit
  function automatic logic [CNT_W-1:0] pick_count(int unsigned lo, int unsigned hi,
                                                 int unsigned bad_pct);
    if ($urandom_range(0, 99) < bad_pct) begin
      if ($urandom_range(0, 3) == 0) return '0;
      return CNT_W'($urandom_range(hi + 1, 127));
    end
    return CNT_W'($urandom_range(lo, hi));
  endfunction

  task automatic send_random(input traffic_mix_e mix);
    int unsigned      roll;
    logic [CMD_W-1:0] cmd;
    logic [CNT_W-1:0] count;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (roll < 90) begin
          cmd   = CMD_WRITE;
          count = (roll < 68) ? CNT_W'(WORD_BYTES) : pick_count(1, WORD_BYTES, 0);
        end else if (roll < 94) begin
          cmd   = CMD_PEEK;
          count = pick_count(1, MAX_BURST_DEF, 0);
        end else if (roll < 97) begin
          cmd   = CMD_QUERY;
          count = CNT_W'($urandom);
        end else begin
          cmd   = CMD_UNUSED_6;
          count = CNT_W'($urandom);
        end
      end
      MIX_DRAIN: begin
        if (roll < 15) begin
          cmd   = CMD_WRITE;
          count = pick_count(1, WORD_BYTES, 0);
        end else if (roll < 50) begin
          cmd   = CMD_READ;
          count = pick_count(16, MAX_BURST_DEF, 0);
        end else if (roll < 65) begin
          cmd   = CMD_REMOVE;
          count = pick_count(1, MAX_BURST_DEF, 0);
        end else if (roll < 85) begin
          cmd   = CMD_WORD;
          count = pick_count(1, WORD_BYTES, 0);
        end else if (roll < 95) begin
          cmd   = CMD_PEEK;
          count = pick_count(1, MAX_BURST_DEF, 0);
        end else begin
          cmd   = CMD_QUERY;
          count = CNT_W'($urandom);
        end
      end
      default: begin
        if (roll < 35) begin
          cmd   = CMD_WRITE;
          count = pick_count(1, WORD_BYTES, 8);
        end else if (roll < 50) begin
          cmd   = CMD_READ;
          count = pick_count(1, ($urandom_range(0, 3) == 0) ? MAX_BURST_DEF : 12, 6);
        end else if (roll < 60) begin
          cmd   = CMD_PEEK;
          count = pick_count(1, ($urandom_range(0, 3) == 0) ? MAX_BURST_DEF : 12, 6);
        end else if (roll < 70) begin
          cmd   = CMD_REMOVE;
          count = pick_count(1, ($urandom_range(0, 3) == 0) ? MAX_BURST_DEF : 8, 6);
        end else if (roll < 85) begin
          cmd   = CMD_WORD;
          count = pick_count(1, WORD_BYTES, 8);
        end else if (roll < 93) begin
          cmd   = CMD_QUERY;
          count = CNT_W'($urandom);
        end else begin
          cmd   = ($urandom_range(0, 1) == 0) ? CMD_UNUSED_6 : CMD_UNUSED_7;
          count = CNT_W'($urandom);
        end
      end
    endcase
    send_request(cmd, $urandom, count);
    pace_requests();
  endtask

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    cmd_i         = CMD_QUERY;
    value_i       = '0;
    count_i       = '0;
    request_count = 0;
    no_idle       = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty ring: query, short reads and words, remove of nothing
    send_request(CMD_QUERY,  32'hFFFF_FFFF, 7'd127); pace_requests();
    send_request(CMD_READ,   32'h0,         7'd1);   pace_requests();
    send_request(CMD_PEEK,   32'h0,         7'd64);  pace_requests();
    send_request(CMD_REMOVE, 32'h0,         7'd64);  pace_requests();
    send_request(CMD_WORD,   32'h0,         7'd4);   pace_requests();
    // write counts outside the legal range
    send_request(CMD_WRITE,  32'hFFFF_FFFF, 7'd0);   pace_requests();
    send_request(CMD_WRITE,  32'hFFFF_FFFF, 7'd5);   pace_requests();
    send_request(CMD_WRITE,  32'hFFFF_FFFF, 7'd127); pace_requests();
    // legal writes of every width, upper value bits ignored
    send_request(CMD_WRITE,  32'hFFFF_FFFF, 7'd4);   pace_requests();
    send_request(CMD_WRITE,  32'hFFFF_FF00, 7'd1);   pace_requests();
    send_request(CMD_WRITE,  32'h1234_5678, 7'd2);   pace_requests();
    send_request(CMD_WRITE,  32'hA5C3_0F81, 7'd3);   pace_requests();
    // bad counts for the other requests and the undefined codes
    send_request(CMD_READ,   32'h0,         7'd0);   pace_requests();
    send_request(CMD_READ,   32'h0,         7'd65);  pace_requests();
    send_request(CMD_PEEK,   32'h0,         7'd127); pace_requests();
    send_request(CMD_REMOVE, 32'h0,         7'd0);   pace_requests();
    send_request(CMD_REMOVE, 32'h0,         7'd65);  pace_requests();
    send_request(CMD_WORD,   32'h0,         7'd0);   pace_requests();
    send_request(CMD_WORD,   32'h0,         7'd5);   pace_requests();
    send_request(CMD_UNUSED_6, 32'hFFFF_FFFF, 7'd127); pace_requests();
    send_request(CMD_UNUSED_7, 32'h0,         7'd0);   pace_requests();
    // word reads, short peek and read bursts, remove when short
    send_request(CMD_WORD,   32'h0,         7'd3);   pace_requests();
    send_request(CMD_PEEK,   32'h0,         7'd64);  pace_requests();
    send_request(CMD_WORD,   32'h0,         7'd4);   pace_requests();
    send_request(CMD_READ,   32'h0,         7'd64);  pace_requests();
    send_request(CMD_WRITE,  32'h0000_BEEF, 7'd2);   pace_requests();
    send_request(CMD_REMOVE, 32'h0,         7'd3);   pace_requests();

    // mixed traffic, then a full pause
    repeat (60) send_random(MIX_BALANCED);
    wait_all_results();

    // fill the ring until writes overflow a few times
    fill_requests = 0;
    while (overflow_count < OVERFLOW_GOAL && fill_requests < 400) begin
      send_random(MIX_FILL);
      fill_requests++;
    end
    wait_all_results();

    // drain, then mixed traffic to the end
    repeat (90) send_random(MIX_DRAIN);
    while (request_count < ITEM_TARGET) send_random(MIX_BALANCED);

    wait_all_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
